/* hw/rtl/assert_macros.svh */
// Assertion helpers; every user must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* hw/rtl/a2s_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package a2s_pkg;

	// register indexes on the config port
	localparam logic [1:0] REG_RELEASE_MASK = 2'd0;
	localparam logic [1:0] REG_LEFT_SHIFT   = 2'd1;
	localparam logic [1:0] REG_RIGHT_SHIFT  = 2'd2;

	localparam logic [7:0] RELEASE_MASK_RST = 8'h80;
	localparam logic [7:0] LEFT_SHIFT_RST   = 8'h2A;
	localparam logic [7:0] RIGHT_SHIFT_RST  = 8'h36;

	localparam logic [6:0] CHAR_DEL     = 7'h7F;
	localparam logic       REQ_BEGIN    = 1'b0;
	localparam logic       Q_CHAR       = 1'b0;
	localparam logic       Q_RAW        = 1'b1;
	localparam int         MAX_RESULTS  = 4;
	localparam int         CNT_W        = $clog2(MAX_RESULTS + 1);

	typedef struct packed {
		logic       req_type;
		logic [7:0] character;
	} item_t;

	typedef struct packed {
		logic [7:0] release_mask;
		logic [7:0] left_shift_code;
		logic [7:0] right_shift_code;
	} cfg_t;

	typedef struct packed {
		logic       queue_select;
		logic [7:0] key_code;
	} ent_t;

	typedef struct packed {
		ent_t [MAX_RESULTS-1:0] ent;   // ent[0] goes out first
		logic [CNT_W-1:0]       cnt;
	} list_t;

	typedef struct packed {
		logic       shift;
		logic [7:0] make;
	} rom_ent_t;

	// character -> {needs shift, make code}; zero means no key
	function automatic rom_ent_t key_rom(input logic [6:0] ch);
		logic [8:0] e;
		unique case (ch)
			7'h20: e = 9'h039;  7'h21: e = 9'h102;  7'h22: e = 9'h128;  7'h23: e = 9'h104;
			7'h24: e = 9'h105;  7'h25: e = 9'h106;  7'h26: e = 9'h108;  7'h27: e = 9'h028;
			7'h28: e = 9'h10A;  7'h29: e = 9'h10B;  7'h2A: e = 9'h109;  7'h2B: e = 9'h10D;
			7'h2C: e = 9'h033;  7'h2D: e = 9'h00C;  7'h2E: e = 9'h034;  7'h2F: e = 9'h035;
			7'h30: e = 9'h00B;  7'h31: e = 9'h002;  7'h32: e = 9'h003;  7'h33: e = 9'h004;
			7'h34: e = 9'h005;  7'h35: e = 9'h006;  7'h36: e = 9'h007;  7'h37: e = 9'h008;
			7'h38: e = 9'h009;  7'h39: e = 9'h00A;  7'h3A: e = 9'h127;  7'h3B: e = 9'h027;
			7'h3C: e = 9'h133;  7'h3D: e = 9'h00D;  7'h3E: e = 9'h134;  7'h3F: e = 9'h135;
			7'h40: e = 9'h103;  7'h41: e = 9'h11E;  7'h42: e = 9'h130;  7'h43: e = 9'h12E;
			7'h44: e = 9'h120;  7'h45: e = 9'h112;  7'h46: e = 9'h121;  7'h47: e = 9'h122;
			7'h48: e = 9'h123;  7'h49: e = 9'h117;  7'h4A: e = 9'h124;  7'h4B: e = 9'h125;
			7'h4C: e = 9'h126;  7'h4D: e = 9'h132;  7'h4E: e = 9'h131;  7'h4F: e = 9'h118;
			7'h50: e = 9'h119;  7'h51: e = 9'h110;  7'h52: e = 9'h113;  7'h53: e = 9'h11F;
			7'h54: e = 9'h114;  7'h55: e = 9'h116;  7'h56: e = 9'h12F;  7'h57: e = 9'h111;
			7'h58: e = 9'h12D;  7'h59: e = 9'h115;  7'h5A: e = 9'h12C;  7'h5B: e = 9'h01A;
			7'h5C: e = 9'h02B;  7'h5D: e = 9'h01B;  7'h5E: e = 9'h107;  7'h5F: e = 9'h10C;
			7'h60: e = 9'h029;  7'h61: e = 9'h01E;  7'h62: e = 9'h030;  7'h63: e = 9'h02E;
			7'h64: e = 9'h020;  7'h65: e = 9'h012;  7'h66: e = 9'h021;  7'h67: e = 9'h022;
			7'h68: e = 9'h023;  7'h69: e = 9'h017;  7'h6A: e = 9'h024;  7'h6B: e = 9'h025;
			7'h6C: e = 9'h026;  7'h6D: e = 9'h032;  7'h6E: e = 9'h031;  7'h6F: e = 9'h018;
			7'h70: e = 9'h019;  7'h71: e = 9'h010;  7'h72: e = 9'h013;  7'h73: e = 9'h01F;
			7'h74: e = 9'h014;  7'h75: e = 9'h016;  7'h76: e = 9'h02F;  7'h77: e = 9'h011;
			7'h78: e = 9'h02D;  7'h79: e = 9'h015;  7'h7A: e = 9'h02C;  7'h7B: e = 9'h11A;
			7'h7C: e = 9'h12B;  7'h7D: e = 9'h11B;  7'h7E: e = 9'h129;
			default: e = 9'h000;
		endcase
		return rom_ent_t'(e);
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/a2s_decode.sv */
`timescale 1ns / 1ps
`default_nettype none
module a2s_decode (
	input  a2s_pkg::item_t  item,
	input  a2s_pkg::cfg_t   cfg,
	input  logic            shift_held,
	output a2s_pkg::list_t  list,
	output logic            shift_held_nxt
);

	a2s_pkg::rom_ent_t rom;
	a2s_pkg::ent_t     ent_make;
	a2s_pkg::ent_t     ent_break;
	a2s_pkg::ent_t     ent_shift;
	logic              chg;
	logic [7:0]        shift_release;

	assign rom           = a2s_pkg::key_rom(item.character[6:0]);
	assign shift_release = cfg.release_mask | cfg.left_shift_code;
	assign chg           = rom.shift ^ shift_held;
	assign ent_make      = '{queue_select: a2s_pkg::Q_RAW, key_code: rom.make};
	assign ent_break     = '{queue_select: a2s_pkg::Q_RAW,
	                         key_code: cfg.release_mask | rom.make};
	assign ent_shift     = '{queue_select: a2s_pkg::Q_RAW,
	                         key_code: rom.shift ? cfg.left_shift_code : shift_release};

	always_comb begin
		list           = '0;
		shift_held_nxt = shift_held;
		if (item.req_type == a2s_pkg::REQ_BEGIN) begin
			list.ent[0]    = '{queue_select: a2s_pkg::Q_RAW, key_code: shift_release};
			list.ent[1]    = '{queue_select: a2s_pkg::Q_RAW,
			                   key_code: cfg.release_mask | cfg.right_shift_code};
			list.cnt       = a2s_pkg::CNT_W'(2);
			shift_held_nxt = 1'b0;
		end else if (!item.character[7] && item.character[6:0] != a2s_pkg::CHAR_DEL) begin
			list.ent[0] = '{queue_select: a2s_pkg::Q_CHAR, key_code: item.character};
			if (rom == '0) begin
				list.cnt = a2s_pkg::CNT_W'(1);
			end else begin
				shift_held_nxt = rom.shift;
				if (chg) begin
					list.ent[1] = ent_shift;
					list.ent[2] = ent_make;
					list.ent[3] = ent_break;
					list.cnt    = a2s_pkg::CNT_W'(4);
				end else begin
					list.ent[1] = ent_make;
					list.ent[2] = ent_break;
					list.cnt    = a2s_pkg::CNT_W'(3);
				end
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/a2s_emitter.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module a2s_emitter (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  a2s_pkg::list_t  list,
	output logic            load_ok,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,   // key_code[7:0]
	output logic            m_tuser,   // queue_select
	output logic            m_tlast
);

	a2s_pkg::ent_t [a2s_pkg::MAX_RESULTS-1:0] ent_q;
	logic [a2s_pkg::CNT_W-1:0]                cnt_q;

	assign m_tvalid = (cnt_q != '0);
	assign m_tlast  = (cnt_q == a2s_pkg::CNT_W'(1));
	assign m_tdata  = ent_q[0].key_code;
	assign m_tuser  = ent_q[0].queue_select;
	// a new list may come in over the final beat of the current one
	assign load_ok  = !m_tvalid || (m_tlast && m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= list.cnt;
		end else if (m_tvalid && m_tready) begin
			cnt_q <= cnt_q - a2s_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= list.ent;
		end else if (m_tvalid && m_tready) begin
			for (int i = 0; i < a2s_pkg::MAX_RESULTS - 1; i++) begin
				ent_q[i] <= ent_q[i+1];
			end
		end
	end

	`ASSERT_NEVER(a_cnt_range, cnt_q > a2s_pkg::CNT_W'(a2s_pkg::MAX_RESULTS), "result count overflow")
	`ASSERT_CLK(a_drain, (m_tvalid && m_tready && m_tlast && !load) |=> !m_tvalid, "beat after last")
	`ASSERT_CLK(a_load_shows, (load && list.cnt != '0) |=> m_tvalid, "loaded list not shown")
	`ASSERT_NEVER(a_load_overrun, load && m_tvalid && !(m_tlast && m_tready), "list overwritten")

endmodule
`default_nettype wire

/* hw/rtl/ascii_to_scancode_keystroke_injector.sv */
// The first result of an item appears once its input beat is registered in item_s1 and
//   its decoded list is loaded into the emitter's result buffer, which waits for load_ok.
// Each item gives 0..4 results, drained by the single result port from the result buffer
//   one beat per cycle while m_tready is high.
// The next item is decoded and held while the previous one drains.
// Reset (arst_n low, asynchronous): pipeline empty, shift not held, registers at
//   release_mask 0x80, left_shift_code 0x2A, right_shift_code 0x36.
`timescale 1ns / 1ps
`default_nettype none
module ascii_to_scancode_keystroke_injector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // character[7:0]
	input  logic        s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // key_code[7:0]
	output logic        m_tuser,   // queue_select
	output logic        m_tlast
);

	a2s_pkg::cfg_t   cfg_q;
	a2s_pkg::item_t  item_s1;
	logic            valid_s1;
	logic            shift_held_q;
	logic            shift_held_nxt;
	a2s_pkg::list_t  list;
	logic            load_ok;
	logic            load;

	assign load     = valid_s1 && load_ok;
	assign s_tready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.release_mask     <= a2s_pkg::RELEASE_MASK_RST;
			cfg_q.left_shift_code  <= a2s_pkg::LEFT_SHIFT_RST;
			cfg_q.right_shift_code <= a2s_pkg::RIGHT_SHIFT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				a2s_pkg::REG_RELEASE_MASK: cfg_q.release_mask     <= cfg_wdata;
				a2s_pkg::REG_LEFT_SHIFT:   cfg_q.left_shift_code  <= cfg_wdata;
				a2s_pkg::REG_RIGHT_SHIFT:  cfg_q.right_shift_code <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			shift_held_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (load) begin
				shift_held_q <= shift_held_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= '{req_type: s_tuser, character: s_tdata};
		end
	end

	a2s_decode u_decode (
		.item           (item_s1),
		.cfg            (cfg_q),
		.shift_held     (shift_held_q),
		.list           (list),
		.shift_held_nxt (shift_held_nxt)
	);

	a2s_emitter u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.list     (list),
		.load_ok  (load_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire
